FILE: hdl/w_plane_binning_accumulator_top_macros.svh
// Assertion macros shared by the checker of the w-plane binning accumulator.
// No dependencies; included by the checker file.
`ifndef W_PLANE_BINNING_ACCUMULATOR_TOP_MACROS_SVH
`define W_PLANE_BINNING_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WPBA_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WPBA_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define WPBA_ASSERT_NXT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/wpba_pkg.sv
// Shared types and constants of the w-plane binning accumulator.
// No dependencies; used by the interfaces, the top level and the checker.
package wpba_pkg;

  localparam int MAX_PLANES_DEF = 256;

  localparam int FUNC_W  = 1;
  localparam int W_W     = 32;
  localparam int RIDX_W  = 8;
  localparam int STAT_W  = 2;
  localparam int PIDX_W  = 8;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 32;
  localparam int NP_W    = 9;
  localparam int RECIP_W = 32;
  localparam int CIDX_W  = 1;
  localparam int CDAT_W  = 32;

  localparam logic [NP_W-1:0]    NUM_PLANES_RST  = NP_W'(256);
  localparam logic [RECIP_W-1:0] RECIP_WSTEP_RST = RECIP_W'(32'h0100_0000);

  typedef enum logic [STAT_W-1:0] {
    ST_BINNED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_READ    = 2'd2
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_NUM_PLANES  = 1'd0,
    CFG_RECIP_WSTEP = 1'd1
  } cfg_reg_t;

  localparam int FUNC_ACCUM = 0;
  localparam int FUNC_READ  = 1;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } plane_entry_t;

endpackage

FILE: hdl/wpba_if.sv
// Valid/ready channel interfaces of the w-plane binning accumulator.
// Depends on wpba_pkg for the field widths.
interface wpba_in_if;
  logic                               valid;
  logic                               ready;
  logic [wpba_pkg::FUNC_W-1:0]        func;
  logic signed [wpba_pkg::W_W-1:0]    w_value;
  logic [wpba_pkg::RIDX_W-1:0]        read_index;

  modport source (output valid, func, w_value, read_index, input ready);
  modport sink   (input valid, func, w_value, read_index, output ready);
endinterface

interface wpba_out_if;
  logic                               valid;
  logic                               ready;
  logic [wpba_pkg::STAT_W-1:0]        status;
  logic [wpba_pkg::PIDX_W-1:0]        plane_index;
  logic signed [wpba_pkg::SUM_W-1:0]  bin_sum;
  logic [wpba_pkg::CNT_W-1:0]         bin_count;

  modport source (output valid, status, plane_index, bin_sum, bin_count, input ready);
  modport sink   (input valid, status, plane_index, bin_sum, bin_count, output ready);
endinterface

interface wpba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wpba_pkg::CIDX_W-1:0]   index;
  logic [wpba_pkg::CDAT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/w_plane_binning_accumulator_top.sv
// Pipeline: a result beat passes through the input register, the multiply register, the
// plane-store read register and the result register.
// Throughput: one item per cycle while the output is not stalled; the store update forwards the
// previous write to the next read. Any output stall holds the whole pipeline.
// Reset: synchronous; a clearing pass then zeroes the plane store, one entry per cycle, over
// all MAX_PLANES entries, during which no input beat is taken (configuration writes still are).
// Top level of the w-plane binning accumulator: binning pipeline and plane store.
// Depends on wpba_pkg and the channel interfaces in wpba_if.sv.
module w_plane_binning_accumulator_top #(
  parameter int MAX_PLANES = wpba_pkg::MAX_PLANES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wpba_in_if.sink     items,
  wpba_out_if.source  results,
  wpba_cfg_if.sink    cfg
);

  localparam int AW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int NW  = $clog2(MAX_PLANES + 1);
  localparam int QW  = 24;
  localparam int PLW = ((QW > NW) ? QW : NW) + 2;
  localparam int PW  = 2 * wpba_pkg::W_W;
  localparam int SW  = wpba_pkg::SUM_W;
  localparam int CW  = wpba_pkg::CNT_W;

  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  // Configuration registers.
  logic [wpba_pkg::NP_W-1:0]    num_planes;
  logic [wpba_pkg::RECIP_W-1:0] recip_wstep;

  // Clearing pass.
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Pipeline.
  logic adv;

  logic                                v1;
  logic                                func1;
  logic signed [wpba_pkg::W_W-1:0]     w1;
  logic [wpba_pkg::RIDX_W-1:0]         ridx1;

  logic                                v2;
  logic                                func2;
  logic                                neg2;
  logic signed [wpba_pkg::W_W-1:0]     w2;
  logic [PW-1:0]                       prod2;
  logic [wpba_pkg::RIDX_W-1:0]         ridx2;

  logic                                v3;
  wpba_pkg::status_t                   st3;
  logic signed [wpba_pkg::W_W-1:0]     w3;
  logic [AW-1:0]                       addr3;
  logic [wpba_pkg::PIDX_W-1:0]         pidx3;
  logic                                rzero3;
  wpba_pkg::plane_entry_t              rd_q;

  logic                                res_valid;
  wpba_pkg::status_t                   res_status;
  logic [wpba_pkg::PIDX_W-1:0]         res_plane;
  logic signed [SW-1:0]                res_sum;
  logic [CW-1:0]                       res_count;

  // Last write into the store, forwarded to the item that read alongside it.
  logic                                fwd_v;
  logic [AW-1:0]                       fwd_addr;
  wpba_pkg::plane_entry_t              fwd_entry;

  wpba_pkg::plane_entry_t              mem [MAX_PLANES];

  // Combinational signals.
  logic [NW-1:0]                       n_eff;
  logic [wpba_pkg::W_W-1:0]            mag1;
  logic [PW-1:0]                       qsum2;
  logic [QW-1:0]                       q2;
  logic signed [PLW-1:0]               sq2;
  logic signed [PLW-1:0]               plane2;
  logic                                in_range2;
  logic                                read_oob2;
  wpba_pkg::status_t                   st2;
  logic [AW-1:0]                       addr2;
  logic [wpba_pkg::PIDX_W-1:0]         pidx2;

  wpba_pkg::plane_entry_t              cur3;
  logic signed [SW:0]                  sum_wide3;
  logic signed [SW-1:0]                sum_new3;
  logic [CW-1:0]                       cnt_new3;
  logic                                we3;

  logic                                mem_we;
  logic [AW-1:0]                       mem_wa;
  wpba_pkg::plane_entry_t              mem_wd;

  assign adv           = !res_valid || results.ready;
  assign items.ready   = adv && !clr_active;
  assign cfg.ready     = 1'b1;

  assign results.valid       = res_valid;
  assign results.status      = res_status;
  assign results.plane_index = res_plane;
  assign results.bin_sum     = res_sum;
  assign results.bin_count   = res_count;

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_planes  <= wpba_pkg::NUM_PLANES_RST;
      recip_wstep <= wpba_pkg::RECIP_WSTEP_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        wpba_pkg::CFG_NUM_PLANES:  num_planes  <= cfg.data[wpba_pkg::NP_W-1:0];
        wpba_pkg::CFG_RECIP_WSTEP: recip_wstep <= cfg.data[wpba_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_planes == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_planes) > 32'(MAX_PLANES)) begin
      n_eff = NW'(MAX_PLANES);
    end else begin
      n_eff = NW'(num_planes);
    end
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MAX_PLANES - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Stage 1: magnitude times reciprocal.
  assign mag1 = w1[wpba_pkg::W_W-1] ? wpba_pkg::W_W'(-w1) : wpba_pkg::W_W'(w1);

  // Stage 2: round half away from zero, centre, range check.
  always_comb begin
    qsum2     = prod2 + (PW'(1) << 39);
    q2        = qsum2[40 +: QW];
    sq2       = neg2 ? -signed'(PLW'(q2)) : signed'(PLW'(q2));
    plane2    = sq2 + signed'(PLW'(n_eff >> 1));
    in_range2 = !plane2[PLW-1] && (plane2 < signed'(PLW'(n_eff)));
    read_oob2 = 32'(ridx2) >= 32'(MAX_PLANES);
    if (func2) begin
      st2   = wpba_pkg::ST_READ;
      addr2 = AW'(ridx2);
      pidx2 = ridx2;
    end else if (in_range2) begin
      st2   = wpba_pkg::ST_BINNED;
      addr2 = AW'(plane2);
      pidx2 = wpba_pkg::PIDX_W'(plane2);
    end else begin
      st2   = wpba_pkg::ST_DROPPED;
      addr2 = AW'(plane2);
      pidx2 = '0;
    end
  end

  // Stage 3: saturating update of the plane entry.
  always_comb begin
    cur3      = (fwd_v && fwd_addr == addr3) ? fwd_entry : rd_q;
    sum_wide3 = {cur3.sum[SW-1], cur3.sum} + (SW+1)'(w3);
    if (sum_wide3[SW] != sum_wide3[SW-1]) begin
      sum_new3 = sum_wide3[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_new3 = sum_wide3[SW-1:0];
    end
    cnt_new3 = (cur3.count == '1) ? cur3.count : cur3.count + CW'(1);
    we3      = adv && v3 && (st3 == wpba_pkg::ST_BINNED);
  end

  always_comb begin
    if (clr_active) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else begin
      mem_we = we3;
      mem_wa = addr3;
      mem_wd = '{sum: sum_new3, count: cnt_new3};
    end
  end

  // Plane store.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_q <= mem[addr2];
    end
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
      fwd_v     <= 1'b0;
    end else begin
      if (adv) begin
        v1        <= items.valid && items.ready;
        v2        <= v1;
        v3        <= v2;
        res_valid <= v3;
      end
      if (we3) begin
        fwd_v <= 1'b1;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      func1  <= items.func == wpba_pkg::FUNC_W'(wpba_pkg::FUNC_READ);
      w1     <= items.w_value;
      ridx1  <= items.read_index;

      func2  <= func1;
      neg2   <= w1[wpba_pkg::W_W-1];
      w2     <= w1;
      prod2  <= PW'(mag1) * PW'(recip_wstep);
      ridx2  <= ridx1;

      st3    <= st2;
      w3     <= w2;
      addr3  <= addr2;
      pidx3  <= pidx2;
      rzero3 <= read_oob2;

      res_status <= st3;
      res_plane  <= pidx3;
      unique case (st3)
        wpba_pkg::ST_BINNED: begin
          res_sum   <= sum_new3;
          res_count <= cnt_new3;
        end
        wpba_pkg::ST_READ: begin
          res_sum   <= rzero3 ? '0 : cur3.sum;
          res_count <= rzero3 ? '0 : cur3.count;
        end
        default: begin
          res_sum   <= '0;
          res_count <= '0;
        end
      endcase
    end
    if (we3) begin
      fwd_addr  <= addr3;
      fwd_entry <= '{sum: sum_new3, count: cnt_new3};
    end
  end

endmodule

FILE: hdl/wpba_checker.sv
// Port-level checker of the w-plane binning accumulator, bound to the top level.
// Depends on wpba_pkg and w_plane_binning_accumulator_top_macros.svh.
`include "w_plane_binning_accumulator_top_macros.svh"

module wpba_port_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [wpba_pkg::STAT_W-1:0]       status,
  input logic [wpba_pkg::PIDX_W-1:0]       plane_index,
  input logic signed [wpba_pkg::SUM_W-1:0] bin_sum,
  input logic [wpba_pkg::CNT_W-1:0]        bin_count
);

  // Reset starts the clearing pass, so nothing is shown and nothing taken just after it.
  `WPBA_ASSERT_NXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid && !in_ready, "beat after reset")

  // A dropped point reports an all-zero result.
  `WPBA_ASSERT_IMP(a_drop_zero, clk, rst, out_valid && status == wpba_pkg::ST_DROPPED, plane_index == '0 && bin_sum == '0 && bin_count == '0, "dropped point with non-zero fields")

  // A binned point has always been counted at least once.
  `WPBA_ASSERT_IMP(a_binned_count, clk, rst, out_valid && status == wpba_pkg::ST_BINNED, bin_count != '0, "binned point with zero count")

  // A stalled result beat holds its payload.
  `WPBA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(plane_index) && $stable(bin_sum) && $stable(bin_count), "stalled result changed")

endmodule

bind w_plane_binning_accumulator_top wpba_port_checker u_wpba_port_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .status      (results.status),
  .plane_index (results.plane_index),
  .bin_sum     (results.bin_sum),
  .bin_count   (results.bin_count)
);
